>>> src/knock_window_integrate_scale_defines.svh
// Assertion macros shared by the knock window integrate and scale block.
`ifndef KNOCK_WINDOW_INTEGRATE_SCALE_DEFINES_SVH
`define KNOCK_WINDOW_INTEGRATE_SCALE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define KWIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define KWIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kwis_pkg.sv
// Shared types and constants of the knock window integrate and scale block.
package kwis_pkg;

  // Field widths.
  localparam int KWIS_TIME_W   = 32;
  localparam int KWIS_SAMPLE_W = 10;
  localparam int KWIS_WLEN_W   = 16;
  localparam int KWIS_KNOCK_W  = 8;

  // Configuration port.
  localparam int KWIS_CFG_IDX_W  = 2;
  localparam int KWIS_CFG_DATA_W = KWIS_WLEN_W;
  localparam logic [KWIS_CFG_IDX_W-1:0] KWIS_REG_WLEN = 2'd0;
  localparam logic [KWIS_CFG_IDX_W-1:0] KWIS_REG_SENS = 2'd1;
  localparam logic [KWIS_WLEN_W-1:0]    KWIS_WLEN_RESET = 16'd2000;

  // Item kinds.
  localparam logic KWIS_CMD_SPARK = 1'b0;
  localparam logic KWIS_CMD_TICK  = 1'b1;

  // Queue between front and back.
  localparam int KWIS_FIFO_DEPTH = 4;

  // Scaling arithmetic: sample * window / elapsed, then * 255 / 1023.
  localparam int KWIS_NUM_W     = KWIS_SAMPLE_W + KWIS_WLEN_W;
  localparam int KWIS_Q_W       = KWIS_SAMPLE_W;
  localparam int KWIS_SCALE_MUL = 255;
  localparam int KWIS_SCALE_DIV = 1023;
  localparam int KWIS_DIV_SH    = 10;
  localparam int KWIS_X_W       = KWIS_Q_W + 8;
  localparam int KWIS_EST_W     = KWIS_X_W + 1 - KWIS_DIV_SH;
  localparam int KWIS_KNOCK_MAX = 255;

  // One classified item as it travels from front to back.
  typedef struct packed {
    logic                     integrate;
    logic                     close;
    logic [KWIS_SAMPLE_W-1:0] sample;
    logic [KWIS_TIME_W-1:0]   elapsed;
  } kwis_entry_t;

endpackage

>>> src/kwis_fifo.sv
// Small queue that decouples the front classifier from the back scaler.
module kwis_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  kwis_pkg::kwis_entry_t wr_data,
  input  logic                 pop,
  output kwis_pkg::kwis_entry_t rd_data,
  output logic                 full,
  output logic                 empty
);
  import kwis_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kwis_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/kwis_front.sv
// Front end: accepts beats, tracks the integration window and classifies each item.
module kwis_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_cmd,
  input  logic [kwis_pkg::KWIS_TIME_W-1:0]   in_now_us,
  input  logic [kwis_pkg::KWIS_SAMPLE_W-1:0] in_adc_sample,
  input  logic                               sensor_available,
  input  logic [kwis_pkg::KWIS_WLEN_W-1:0]   window_length_us,
  input  logic                               queue_full,
  output logic                               in_stall,
  output logic                               push,
  output kwis_pkg::kwis_entry_t              entry,
  output logic                               window_open
);
  import kwis_pkg::*;

  logic                   win_open_r, win_open_nxt;
  logic [KWIS_TIME_W-1:0] win_start_r, win_start_nxt;
  logic [KWIS_TIME_W-1:0] elapsed;
  logic                   accept;
  logic                   is_spark;
  logic                   open_now;
  logic                   close_now;

  assign in_stall    = queue_full;
  assign accept      = in_valid && !queue_full;
  assign push        = accept;
  assign window_open = win_open_r;

  // Classify the beat: a spark may open the window, a tick may close it.
  assign is_spark  = (in_cmd == KWIS_CMD_SPARK);
  assign elapsed   = in_now_us - win_start_r;
  assign open_now  = is_spark && sensor_available && !win_open_r;
  assign close_now = !is_spark && win_open_r &&
                     (elapsed >= KWIS_TIME_W'(window_length_us));

  always_comb begin
    entry.integrate = close_now ? 1'b0 : (win_open_r || open_now);
    entry.close     = close_now;
    entry.sample    = in_adc_sample;
    entry.elapsed   = elapsed;
  end

  // Window state update.
  always_comb begin
    win_open_nxt  = win_open_r;
    win_start_nxt = win_start_r;
    if (accept) begin
      if (open_now) begin
        win_open_nxt  = 1'b1;
        win_start_nxt = in_now_us;
      end else if (close_now) begin
        win_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_open_r  <= 1'b0;
      win_start_r <= '0;
    end else begin
      win_open_r  <= win_open_nxt;
      win_start_r <= win_start_nxt;
    end
  end

endmodule

>>> src/kwis_back.sv
// Back end: scales the sample of a closing tick and drives the result register.
module kwis_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              queue_empty,
  input  kwis_pkg::kwis_entry_t             entry,
  input  logic [kwis_pkg::KWIS_WLEN_W-1:0]  window_length_us,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_integrate,
  output logic                              out_value_ready,
  output logic [kwis_pkg::KWIS_KNOCK_W-1:0] out_knock_value
);
  import kwis_pkg::*;

  localparam int CNT_W = $clog2(KWIS_NUM_W);
  localparam int R_W   = KWIS_X_W + 1;

  typedef enum logic [5:0] {
    BK_IDLE  = 6'b000001,
    BK_MUL   = 6'b000010,
    BK_DIV   = 6'b000100,
    BK_SCALE = 6'b001000,
    BK_EST   = 6'b010000,
    BK_FIN   = 6'b100000
  } bk_state_t;

  bk_state_t               state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [KWIS_KNOCK_W-1:0] last_r, last_nxt;

  logic                     integ_r, integ_nxt;
  logic [KWIS_SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [KWIS_TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [KWIS_NUM_W-1:0]    num_r, num_nxt;
  logic [KWIS_TIME_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [KWIS_X_W-1:0]      x_r, x_nxt;
  logic [KWIS_EST_W-1:0]    est_r, est_nxt;
  logic                     o_integ_r, o_integ_nxt;
  logic                     o_ready_r, o_ready_nxt;
  logic [KWIS_KNOCK_W-1:0]  o_knock_r, o_knock_nxt;

  logic                     can_load;
  logic [KWIS_TIME_W:0]     trial;
  logic                     qbit;
  logic [KWIS_Q_W-1:0]      quot;
  logic [R_W-1:0]           est_prod;
  logic [R_W-1:0]           resid;
  logic [KWIS_EST_W-1:0]    est_fix;
  logic [KWIS_KNOCK_W-1:0]  knock_new;

  assign can_load        = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_integrate   = o_integ_r;
  assign out_value_ready = o_ready_r;
  assign out_knock_value = o_knock_r;

  // One restoring divide step: a quotient bit per cycle.
  assign trial = {rem_r, num_r[KWIS_NUM_W-1]};
  assign qbit  = (trial >= {1'b0, elapsed_r});

  // The quotient never exceeds the sample since elapsed is at least the window.
  assign quot = (elapsed_r == '0) ? '0 : num_r[KWIS_Q_W-1:0];

  // Division by 1023: the estimate is at most one low, one correction fixes it.
  assign est_prod  = R_W'(est_r) * R_W'(KWIS_SCALE_DIV);
  assign resid     = R_W'(x_r) - est_prod;
  assign est_fix   = (resid >= R_W'(KWIS_SCALE_DIV)) ? est_r + 1'b1 : est_r;
  assign knock_new = (est_fix > KWIS_EST_W'(KWIS_KNOCK_MAX)) ?
                     KWIS_KNOCK_W'(KWIS_KNOCK_MAX) : est_fix[KWIS_KNOCK_W-1:0];

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    integ_nxt     = integ_r;
    sample_nxt    = sample_r;
    elapsed_nxt   = elapsed_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    est_nxt       = est_r;
    o_integ_nxt   = o_integ_r;
    o_ready_nxt   = o_ready_r;
    o_knock_nxt   = o_knock_r;
    pop           = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      BK_IDLE: begin
        if (!queue_empty && can_load) begin
          pop = 1'b1;
          if (entry.close) begin
            integ_nxt   = entry.integrate;
            sample_nxt  = entry.sample;
            elapsed_nxt = entry.elapsed;
            state_nxt   = BK_MUL;
          end else begin
            out_valid_nxt = 1'b1;
            o_integ_nxt   = entry.integrate;
            o_ready_nxt   = 1'b0;
            o_knock_nxt   = last_r;
          end
        end
      end
      BK_MUL: begin
        num_nxt   = KWIS_NUM_W'(sample_r) * KWIS_NUM_W'(window_length_us);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        rem_nxt = qbit ? KWIS_TIME_W'(trial - {1'b0, elapsed_r}) : trial[KWIS_TIME_W-1:0];
        num_nxt = {num_r[KWIS_NUM_W-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(KWIS_NUM_W - 1)) begin
          state_nxt = BK_SCALE;
        end
      end
      BK_SCALE: begin
        x_nxt     = KWIS_X_W'(quot) * KWIS_X_W'(KWIS_SCALE_MUL);
        state_nxt = BK_EST;
      end
      BK_EST: begin
        est_nxt   = KWIS_EST_W'((R_W'(x_r) + R_W'(x_r >> KWIS_DIV_SH)) >> KWIS_DIV_SH);
        state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (can_load) begin
          last_nxt      = knock_new;
          out_valid_nxt = 1'b1;
          o_integ_nxt   = integ_r;
          o_ready_nxt   = 1'b1;
          o_knock_nxt   = knock_new;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control state and the stored knock reading.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    integ_r   <= integ_nxt;
    sample_r  <= sample_nxt;
    elapsed_r <= elapsed_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    x_r       <= x_nxt;
    est_r     <= est_nxt;
    o_integ_r <= o_integ_nxt;
    o_ready_r <= o_ready_nxt;
    o_knock_r <= o_knock_nxt;
  end

endmodule

>>> src/knock_window_integrate_scale.sv
// Top level of the knock integration window controller with reading scaling.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_cmd, in_now_us, in_adc_sample
//   out      output     out_valid/out_stall  out_integrate, out_value_ready,
//                                            out_knock_value
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A spark, or a tick that leaves the window as it is, is written to the queue and
// from there to the result register. A tick that closes the window passes through
// the multiply, the 26-step shift-subtract divider, scale, estimate and final states.
// The queue holds up to FIFO_DEPTH classified items, so input beats keep being
// taken while the back end divides or the output is stalled, until the queue is full.
// Reset is synchronous and active low; it closes the window and clears the reading.
`include "knock_window_integrate_scale_defines.svh"

module knock_window_integrate_scale #(
  parameter int FIFO_DEPTH = kwis_pkg::KWIS_FIFO_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [kwis_pkg::KWIS_TIME_W-1:0]     in_now_us,
  input  logic [kwis_pkg::KWIS_SAMPLE_W-1:0]   in_adc_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_integrate,
  output logic                                 out_value_ready,
  output logic [kwis_pkg::KWIS_KNOCK_W-1:0]    out_knock_value,
  input  logic                                 cfg_we,
  input  logic [kwis_pkg::KWIS_CFG_IDX_W-1:0]  cfg_index,
  input  logic [kwis_pkg::KWIS_CFG_DATA_W-1:0] cfg_wdata
);
  import kwis_pkg::*;

  logic [KWIS_WLEN_W-1:0] wlen_r, wlen_nxt;
  logic                   sens_r, sens_nxt;

  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  kwis_entry_t push_entry;
  kwis_entry_t pop_entry;
  logic        win_open;

  // Configuration registers.
  always_comb begin
    wlen_nxt = wlen_r;
    sens_nxt = sens_r;
    if (cfg_we) begin
      unique case (cfg_index)
        KWIS_REG_WLEN: wlen_nxt = cfg_wdata[KWIS_WLEN_W-1:0];
        KWIS_REG_SENS: sens_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= KWIS_WLEN_RESET;
      sens_r <= 1'b0;
    end else begin
      wlen_r <= wlen_nxt;
      sens_r <= sens_nxt;
    end
  end

  kwis_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_cmd           (in_cmd),
    .in_now_us        (in_now_us),
    .in_adc_sample    (in_adc_sample),
    .sensor_available (sens_r),
    .window_length_us (wlen_r),
    .queue_full       (q_full),
    .in_stall         (in_stall),
    .push             (push),
    .entry            (push_entry),
    .window_open      (win_open)
  );

  kwis_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (pop_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  kwis_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .queue_empty      (q_empty),
    .entry            (pop_entry),
    .window_length_us (wlen_r),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_integrate    (out_integrate),
    .out_value_ready  (out_value_ready),
    .out_knock_value  (out_knock_value)
  );

  // A closing result always puts the integrator on hold.
  `KWIS_ASSERT_NOW(a_close_holds, clk, rst_n, out_valid && out_value_ready, !out_integrate, "closing result with integrate set")
  // A spark taken while the sensor is unavailable leaves the window alone.
  `KWIS_ASSERT_NEXT(a_spark_ignored, clk, rst_n, in_valid && !in_stall && (in_cmd == KWIS_CMD_SPARK) && !sens_r, win_open == $past(win_open), "spark moved window without sensor")
  // A tick never opens a closed window.
  `KWIS_ASSERT_NEXT(a_tick_no_open, clk, rst_n, in_valid && !in_stall && (in_cmd == KWIS_CMD_TICK) && !win_open, !win_open, "tick opened the window")

endmodule
